>>> rtl/aip_pkg.sv
package aip_pkg;

    // Sizes of the string, the result and the radix.
    localparam int MAX_STRING_LEN = 64;
    localparam int VALUE_W        = 32;
    localparam int POS_W          = $clog2(MAX_STRING_LEN + 1);
    localparam int BASE_W         = 6;
    localparam int DIGIT_W        = 6;
    localparam int CHAR_W         = 8;
    localparam int STATUS_W       = 2;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = VALUE_W;
    localparam int PROD_W         = VALUE_W + BASE_W + 1;

    // Depth of the queue between the classifier and the parser.
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

    // Saturation limits of the magnitude.
    localparam logic [PROD_W-1:0] LIM_POS = PROD_W'((64'd1 << (VALUE_W - 1)) - 64'd1);
    localparam logic [PROD_W-1:0] LIM_NEG = PROD_W'(64'd1 << (VALUE_W - 1));
    localparam logic [VALUE_W-1:0] MOST_NEG = VALUE_W'(64'd1 << (VALUE_W - 1));

    // Radix values chosen by the prefix rules.
    localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_BASE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_VALUE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VALUE   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_EN    = 2'd3;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    // One classified character as it travels through the queue.
    typedef struct packed {
        logic               is_space;
        logic               is_minus;
        logic               is_plus;
        logic               is_zero;
        logic               is_x;
        logic               is_alnum;
        logic [DIGIT_W-1:0] digit;
        logic [POS_W-1:0]   pos;
        logic               last;
    } word_t;

    // Parse state captured at the end of a string.
    typedef struct packed {
        logic                neg;
        logic [VALUE_W-1:0]  acc;
        logic [STATUS_W-1:0] sat;
        logic                digits;
        logic [POS_W-1:0]    end_pos;
    } snap_t;

    // Configuration as seen by the parser and the result stage.
    typedef struct packed {
        logic [BASE_W-1:0]  number_base;
        logic [VALUE_W-1:0] min_value;
        logic [VALUE_W-1:0] max_value;
        logic               range_check;
    } cfg_t;

endpackage

>>> rtl/aip_front.sv
module aip_front
    import aip_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] char_byte,
    input  logic              last_char,
    output logic              push,
    output word_t             push_word,
    input  logic              queue_room
);

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              beyond;
    logic [CHAR_W-1:0] c;

    assign in_ready = queue_room;
    assign push     = in_valid && queue_room;

    // Characters past the length limit read as NUL.
    assign beyond = (pos_reg >= POS_W'(MAX_STRING_LEN));
    assign c      = beyond ? '0 : char_byte;

    // Classify the character and decode its digit value.
    always_comb
    begin
        push_word          = '0;
        push_word.is_space = (c inside {[8'h09:8'h0D], 8'h20});
        push_word.is_minus = (c == 8'h2D);
        push_word.is_plus  = (c == 8'h2B);
        push_word.is_zero  = (c == 8'h30);
        push_word.is_x     = (c == 8'h78) || (c == 8'h58);
        push_word.pos      = pos_reg;
        push_word.last     = last_char;
        if (c inside {[8'h30:8'h39]})
        begin
            push_word.is_alnum = 1'b1;
            push_word.digit    = DIGIT_W'(c - 8'h30);
        end
        else if (c inside {[8'h41:8'h5A]})
        begin
            push_word.is_alnum = 1'b1;
            push_word.digit    = DIGIT_W'(c - 8'h37);
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            push_word.is_alnum = 1'b1;
            push_word.digit    = DIGIT_W'(c - 8'h57);
        end
    end

    // Position counter: stops at the limit, restarts after the last character.
    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (last_char)
                pos_next = '0;
            else if (!beyond)
                pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

>>> rtl/aip_queue.sv
module aip_queue
    import aip_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  word_t push_word,
    output logic  room,
    output logic  valid,
    output word_t head,
    input  logic  pop
);

    word_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign room  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + QUEUE_PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + QUEUE_PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue popped while empty");

endmodule

>>> rtl/aip_core.sv
module aip_core
    import aip_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  q_valid,
    input  word_t q_word,
    output logic  q_pop,
    output logic  snap_valid,
    output snap_t snap,
    input  logic  snap_ready
);

    phase_t              phase_reg;
    phase_t              phase_next;
    phase_t              phase_step;
    phase_t              eff_phase;
    logic                neg_reg;
    logic                neg_next;
    logic                neg_step;
    logic [VALUE_W-1:0]  acc_reg;
    logic [VALUE_W-1:0]  acc_next;
    logic [VALUE_W-1:0]  acc_step;
    logic [STATUS_W-1:0] sat_reg;
    logic [STATUS_W-1:0] sat_next;
    logic [STATUS_W-1:0] sat_step;
    logic [BASE_W-1:0]   base_reg;
    logic [BASE_W-1:0]   base_next;
    logic [BASE_W-1:0]   base_step;
    logic                ds_reg;
    logic                ds_next;
    logic                ds_step;
    logic [POS_W-1:0]    end_reg;
    logic [POS_W-1:0]    end_next;
    logic [POS_W-1:0]    end_step;
    logic                snap_valid_reg;
    logic                snap_valid_next;
    snap_t               snap_reg;
    snap_t               snap_next;

    logic                       snap_free;
    logic                       zero_branch;
    logic                       take;
    logic [BASE_W-1:0]          take_base;
    logic                       digit_ok;
    logic [VALUE_W+BASE_W-1:0]  prod;
    logic [PROD_W-1:0]          wide;
    logic [PROD_W-1:0]          lim;
    logic                       ovf;
    logic [POS_W-1:0]           pos_inc;

    // A last word waits until the capture register is free.
    assign snap_free = !snap_valid_reg || snap_ready;
    assign q_pop     = q_valid && (!q_word.last || snap_free);

    // A character that is neither blank nor sign leaves the blank phase at once.
    always_comb
    begin
        eff_phase = phase_reg;
        if (phase_reg == PH_SPACE && !q_word.is_space && !q_word.is_minus
            && !q_word.is_plus)
            eff_phase = PH_SIGNED;
    end

    assign zero_branch = (cfg.number_base == '0 || cfg.number_base == BASE_HEX)
                         && q_word.is_zero;

    // Radix for this character and whether it goes to the digit unit.
    always_comb
    begin
        take      = 1'b0;
        take_base = base_reg;
        case (eff_phase)
            PH_SIGNED:
            begin
                take      = !zero_branch;
                take_base = (cfg.number_base == '0) ? BASE_DEC : cfg.number_base;
            end
            PH_ZERO:
            begin
                take      = !q_word.is_x;
                take_base = (cfg.number_base == '0) ? BASE_OCT : cfg.number_base;
            end
            PH_PREFIX, PH_DIGITS:
                take = 1'b1;
            default:
                take = 1'b0;
        endcase
    end

    // Digit unit: one multiply-add and a compare against the limit.
    assign digit_ok = q_word.is_alnum && (q_word.digit < take_base);
    assign prod     = (VALUE_W + BASE_W)'(acc_reg) * (VALUE_W + BASE_W)'(take_base);
    assign wide     = PROD_W'(prod) + PROD_W'(q_word.digit);
    assign lim      = neg_reg ? LIM_NEG : LIM_POS;
    assign ovf      = (wide > lim);
    assign pos_inc  = q_word.pos + POS_W'(1);

    // Phase transition for one character.
    always_comb
    begin
        case (eff_phase)
            PH_SPACE:
                phase_step = (q_word.is_minus || q_word.is_plus) ? PH_SIGNED : PH_SPACE;
            PH_SIGNED:
                if (zero_branch)
                    phase_step = PH_ZERO;
                else
                    phase_step = digit_ok ? PH_DIGITS : PH_DONE;
            PH_ZERO:
                if (q_word.is_x)
                    phase_step = PH_PREFIX;
                else
                    phase_step = digit_ok ? PH_DIGITS : PH_DONE;
            PH_PREFIX, PH_DIGITS:
                phase_step = digit_ok ? PH_DIGITS : PH_DONE;
            PH_DONE:
                phase_step = PH_DONE;
            default:
                phase_step = PH_SPACE;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (q_pop)
            phase_next = q_word.last ? PH_SPACE : phase_step;
    end

    // Datapath update for one character.
    always_comb
    begin
        neg_step  = neg_reg;
        acc_step  = acc_reg;
        sat_step  = sat_reg;
        base_step = base_reg;
        ds_step   = ds_reg;
        end_step  = end_reg;
        case (eff_phase)
            PH_SPACE:
                if (q_word.is_minus)
                    neg_step = 1'b1;
            PH_SIGNED:
                if (!zero_branch)
                    base_step = take_base;
            PH_ZERO:
                if (q_word.is_x)
                    base_step = BASE_HEX;
                else
                begin
                    // The held zero counts as a digit of its own.
                    base_step = take_base;
                    ds_step   = 1'b1;
                    end_step  = q_word.pos;
                end
            default:
                base_step = base_reg;
        endcase
        if (take && digit_ok)
        begin
            ds_step  = 1'b1;
            end_step = pos_inc;
            if (sat_reg == ST_OK)
            begin
                if (ovf)
                begin
                    acc_step = lim[VALUE_W-1:0];
                    sat_step = neg_reg ? ST_UNDER : ST_OVER;
                end
                else
                    acc_step = wide[VALUE_W-1:0];
            end
        end
    end

    // State after the word: cleared at the end of a string.
    always_comb
    begin
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        sat_next  = sat_reg;
        base_next = base_reg;
        ds_next   = ds_reg;
        end_next  = end_reg;
        if (q_pop)
        begin
            if (q_word.last)
            begin
                neg_next  = 1'b0;
                acc_next  = '0;
                sat_next  = ST_OK;
                base_next = '0;
                ds_next   = 1'b0;
                end_next  = '0;
            end
            else
            begin
                neg_next  = neg_step;
                acc_next  = acc_step;
                sat_next  = sat_step;
                base_next = base_step;
                ds_next   = ds_step;
                end_next  = end_step;
            end
        end
    end

    // Capture at the end of a string; a lone held zero is a complete number.
    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        snap_next       = snap_reg;
        if (q_pop && q_word.last)
        begin
            snap_valid_next   = 1'b1;
            snap_next.neg     = neg_step;
            snap_next.acc     = acc_step;
            snap_next.sat     = sat_step;
            snap_next.digits  = ds_step || (phase_step == PH_ZERO);
            snap_next.end_pos = (phase_step == PH_ZERO) ? pos_inc : end_step;
        end
        else if (snap_ready)
            snap_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SPACE;
            neg_reg        <= 1'b0;
            acc_reg        <= '0;
            sat_reg        <= ST_OK;
            base_reg       <= '0;
            ds_reg         <= 1'b0;
            end_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            neg_reg        <= neg_next;
            acc_reg        <= acc_next;
            sat_reg        <= sat_next;
            base_reg       <= base_next;
            ds_reg         <= ds_next;
            end_reg        <= end_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_word.last) |=> (phase_reg == PH_SPACE && acc_reg == '0
                                    && snap_valid_reg))
        else $error("parse state not cleared after the end of a string");

    a_sat_needs_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (sat_reg != ST_OK) |-> ds_reg)
        else $error("saturation flagged without any digit");

endmodule

>>> rtl/aip_finish.sv
module aip_finish
    import aip_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       snap_valid,
    input  snap_t                      snap,
    output logic                       snap_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [VALUE_W-1:0]  value,
    output logic [STATUS_W-1:0]        status,
    output logic [POS_W-1:0]           chars_consumed
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [VALUE_W-1:0]   value_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [POS_W-1:0]     chars_reg;
    logic [VALUE_W-1:0]   signed_val;
    logic                 range_fail;

    assign snap_ready = !out_valid_reg || out_ready;

    // Apply the sign, then the optional range window.
    assign signed_val = snap.neg ? (~snap.acc + VALUE_W'(1)) : snap.acc;
    assign range_fail = cfg.range_check &&
                        (($signed(signed_val) < $signed(cfg.min_value)) ||
                         ($signed(signed_val) > $signed(cfg.max_value)));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (snap_valid && snap_ready)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (snap_valid && snap_ready)
        begin
            value_reg  <= range_fail ? MOST_NEG : signed_val;
            status_reg <= range_fail ? ST_RANGE : snap.sat;
            chars_reg  <= snap.digits ? snap.end_pos : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign value          = $signed(value_reg);
    assign status         = status_reg;
    assign chars_consumed = chars_reg;

    a_range_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_RANGE) |-> (value_reg == MOST_NEG))
        else $error("range failure without the most negative value");

endmodule

>>> rtl/ascii_integer_parser_top.sv
// Streaming string-to-integer converter. Each accepted word is one ASCII
// byte; the byte with last_char set ends the string and produces one result
// (value, status, chars_consumed) via the queue, the parser's capture
// register and the output register. The block takes one byte per clock while
// the output is not stalled; that figure is set by the parser's multiply-add
// loop, which folds one digit into the 32-bit accumulator each cycle. A
// two-word queue separates the character classifier from the parser, and an
// output register holds the result; an output stall fills the queue, then the input.
// Configuration registers may be written only while no string is in flight.
module ascii_integer_parser_top
    import aip_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CHAR_W-1:0]          char_byte,
    input  logic                       last_char,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [VALUE_W-1:0]  value,
    output logic [STATUS_W-1:0]        status,
    output logic [POS_W-1:0]           chars_consumed,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  push;
    word_t push_word;
    logic  queue_room;
    logic  q_valid;
    word_t q_word;
    logic  q_pop;
    logic  snap_valid;
    snap_t snap;
    logic  snap_ready;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_NUMBER_BASE: cfg_next.number_base = cfg_data[BASE_W-1:0];
                CFG_MIN_VALUE:   cfg_next.min_value   = cfg_data[VALUE_W-1:0];
                CFG_MAX_VALUE:   cfg_next.max_value   = cfg_data[VALUE_W-1:0];
                CFG_RANGE_EN:    cfg_next.range_check = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.number_base <= BASE_DEC;
            cfg_reg.min_value   <= MOST_NEG;
            cfg_reg.max_value   <= LIM_POS[VALUE_W-1:0];
            cfg_reg.range_check <= 1'b0;
        end
        else
            cfg_reg <= cfg_next;
    end

    aip_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_byte  (char_byte),
        .last_char  (last_char),
        .push       (push),
        .push_word  (push_word),
        .queue_room (queue_room)
    );

    aip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .room      (queue_room),
        .valid     (q_valid),
        .head      (q_word),
        .pop       (q_pop)
    );

    aip_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_word     (q_word),
        .q_pop      (q_pop),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready)
    );

    aip_finish u_finish (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .snap_valid     (snap_valid),
        .snap           (snap),
        .snap_ready     (snap_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .value          (value),
        .status         (status),
        .chars_consumed (chars_consumed)
    );

endmodule
